/* design/gpzs_pkg.sv */
// package: widths, register indexes and sizing constants for the grid zero-sum path checker
package gpzs_pkg;

    // largest grid side supported by default
    localparam int MAX_DIM_DEFAULT = 16;

    // width of the grid dimension registers
    localparam int DIM_W = 5;

    // width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

endpackage

/* design/gpzs_if.sv */
// interfaces: configuration write, cell input and result channels
interface gpzs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gpzs_pkg::CFG_IDX_W-1:0] index;
    logic [gpzs_pkg::DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface gpzs_cell_if;
    logic valid;
    logic ready;
    logic cell_negative;

    modport source (output valid, output cell_negative, input ready);
    modport sink   (input valid, input cell_negative, output ready);
endinterface

interface gpzs_result_if;
    logic valid;
    logic ready;
    logic zero_path_found;

    modport source (output valid, output zero_path_found, input ready);
    modport sink   (input valid, input zero_path_found, output ready);
endinterface

/* design/grid_path_zero_sum_check.sv */
// top level: monotone zero-sum path check over a +1/-1 grid, one cell per cycle while no result stalls
//
// usage: write grid_rows (index 0) and grid_cols (index 1) on the cfg channel
// while the block is idle; each write restarts the grid at the top-left cell.
// a value of 0 acts as 1 and a value above MAX_DIM acts as MAX_DIM.
// cells then arrive on the cells channel in row-major order, one beat each.
// after the last cell of the grid one beat leaves on the results channel,
// zero_path_found = 1 if some right/down path sums to zero.
// throughput: one cell beat per cycle unless the compute stage holds a last
// cell that waits for the output register; the row of sum sets lives in a
// single-port-read memory with a registered read, read when a cell is taken
// and written back when it leaves the compute stage, with forwarding when a
// one column grid reads the entry that is being written.
// output: the last cell passes the compute stage register, then the output register.
// reset: grid size returns to 1 x 1, the position to the top-left cell and
// the pipeline and output register empty; the memory is not cleared, row 0
// never uses what it reads.
// stall: the result stays in its output register; cells keep flowing until
// the last cell of the next grid has to wait for that register to free.
module grid_path_zero_sum_check #(
    parameter int MAX_DIM = gpzs_pkg::MAX_DIM_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gpzs_cfg_if.sink             cfg,
    gpzs_cell_if.sink            cells,
    gpzs_result_if.source        results
);

    localparam int SUM_BIAS = 2 * MAX_DIM - 1;
    localparam int SET_W    = 2 * SUM_BIAS + 1;
    localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W    = gpzs_pkg::DIM_W;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] ONE_V     = DIM_W'(1);

    // configuration registers
    logic [DIM_W-1:0] grid_rows_reg;
    logic [DIM_W-1:0] grid_cols_reg;
    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;

    // grid position of the next cell
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;
    logic             last_col;
    logic             last_row;

    // row memory and read data
    logic [SET_W-1:0] row_mem [MAX_DIM];
    logic [SET_W-1:0] mem_q_reg;

    // compute stage
    logic             s1_valid_reg;
    logic             s1_neg_reg;
    logic             s1_first_row_reg;
    logic             s1_first_col_reg;
    logic             s1_last_reg;
    logic             s1_even_reg;
    logic [IDX_W-1:0] s1_col_reg;
    logic [SET_W-1:0] left_reg;
    logic             fwd_reg;
    logic [SET_W-1:0] fwd_data_reg;
    logic [SET_W-1:0] above;
    logic [SET_W-1:0] incoming;
    logic [SET_W-1:0] sums;
    logic             s1_advance;
    logic             cell_accept;
    logic             cfg_write;

    // output register
    logic             out_valid_reg;
    logic             out_found_reg;

    // effective grid size
    always_comb
    begin
        if (grid_rows_reg == '0)
            rows_eff = ONE_V;
        else if (grid_rows_reg > MAX_DIM_V)
            rows_eff = MAX_DIM_V;
        else
            rows_eff = grid_rows_reg;

        if (grid_cols_reg == '0)
            cols_eff = ONE_V;
        else if (grid_cols_reg > MAX_DIM_V)
            cols_eff = MAX_DIM_V;
        else
            cols_eff = grid_cols_reg;
    end

    assign last_col = (DIM_W'(col_reg) + ONE_V) == cols_eff;
    assign last_row = (DIM_W'(row_reg) + ONE_V) == rows_eff;

    // handshakes
    assign cfg.ready   = 1'b1;
    assign cfg_write   = cfg.valid && (cfg.index == gpzs_pkg::REG_GRID_ROWS ||
                                       cfg.index == gpzs_pkg::REG_GRID_COLS);
    assign s1_advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || results.ready);
    assign cells.ready = !s1_valid_reg || s1_advance;
    assign cell_accept = cells.valid && cells.ready;

    // configuration registers and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ONE_V;
            grid_cols_reg <= ONE_V;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg.index == gpzs_pkg::REG_GRID_ROWS)
                grid_rows_reg <= cfg.data;
            else
                grid_cols_reg <= cfg.data;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cell_accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_reg <= col_reg + IDX_W'(1);
            end
        end
    end

    // compute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cell_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    // compute stage payload and forwarding of the entry being written
    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            s1_neg_reg       <= cells.cell_negative;
            s1_first_row_reg <= (row_reg == '0);
            s1_first_col_reg <= (col_reg == '0);
            s1_last_reg      <= last_col && last_row;
            s1_even_reg      <= rows_eff[0] ^ cols_eff[0];
            s1_col_reg       <= col_reg;
            fwd_reg          <= s1_advance && (s1_col_reg == col_reg);
            fwd_data_reg     <= sums;
        end
        if (s1_advance)
            left_reg <= sums;
    end

    // row memory: read at cell accept, write back when the cell completes
    always_ff @(posedge clk)
    begin
        if (cell_accept)
            mem_q_reg <= row_mem[col_reg];
        if (s1_advance)
            row_mem[s1_col_reg] <= sums;
    end

    // sum set of the current cell
    always_comb
    begin
        above = fwd_reg ? fwd_data_reg : mem_q_reg;
        if (s1_first_row_reg && s1_first_col_reg)
        begin
            incoming = '0;
            incoming[SUM_BIAS] = 1'b1;
        end
        else
        begin
            incoming = (s1_first_row_reg ? '0 : above) | (s1_first_col_reg ? '0 : left_reg);
        end
        sums = s1_neg_reg ? (incoming >> 1) : (incoming << 1);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
            out_found_reg <= s1_even_reg && sums[SUM_BIAS];
    end

    assign results.valid           = out_valid_reg;
    assign results.zero_path_found = out_found_reg;

endmodule
